FILE: hw/rtl/fhc_pkg.sv
// Shared types and constants for the fan health checker.
`default_nettype none
package fhc_pkg;

    // Field widths fixed by the stream format
    localparam int LVL_W = 7;
    localparam int RPM_W = 16;

    // s_tdata layout, lowest bit first
    localparam int IN_LEVEL_LSB   = 0;
    localparam int IN_RPM_LSB     = IN_LEVEL_LSB + LVL_W;
    localparam int OUT_LEVEL_LSB  = IN_RPM_LSB + RPM_W;
    localparam int OUT_RPM_LSB    = OUT_LEVEL_LSB + LVL_W;
    localparam int IN_STABLE_BIT  = OUT_RPM_LSB + RPM_W;
    localparam int OUT_STABLE_BIT = IN_STABLE_BIT + 1;
    localparam int S_TDATA_W      = 48;
    localparam int M_TDATA_W      = 8;

    // Judging rules
    localparam int LOW_LEVEL_LIMIT     = 30;
    localparam int LOW_LEVEL_MIN_RPM   = 10;
    localparam int FIXED_RPM_PER_LEVEL = 38;
    localparam int THRESH_NUM          = 6;
    localparam int THRESH_DEN          = 10;

    // Configuration register indexes
    localparam logic REG_USE_TABLE = 1'b0;
    localparam logic REG_WAIT_MODE = 1'b1;

    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic capture;  // latch item, launch table reads
        logic study;    // write learned rpm for both fans
        logic finish;   // load result, write back unlearned entries
    } dp_cmd_t;

    typedef struct packed {
        logic out_free; // result register can take a word this cycle
    } dp_status_t;

    // Round an 8-bit level down to a multiple of ten (x*205 >> 11 is x/10 here)
    function automatic logic [7:0] round_down_ten(input logic [7:0] v);
        logic [15:0] prod;
        logic [4:0]  q;
        prod = 16'(v) * 16'd205;
        q    = prod[15:11];
        return 8'(q) * 8'd10;
    endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/fhc_ctrl.sv
// Sequencer for the fan health checker: accept, evaluate, hand off result.
`default_nettype none
module fhc_ctrl
    import fhc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic       s_tuser,   // kind: 1 study sample
    output dp_cmd_t         cmd,
    input  wire dp_status_t status
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (s_tuser) begin
                        cmd.study = 1'b1;
                    end else begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_EVAL: begin
                // hold here while the previous result is still unclaimed
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/fhc_datapath.sv
// Datapath: learned rpm tables, learned bits, judging logic and result register.
`default_nettype none
module fhc_datapath
    import fhc_pkg::*;
#(
    parameter int LEVELS   = 101,
    parameter int RPM_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_index,
    input  wire logic                 cfg_data,
    input  wire dp_cmd_t              cmd,
    output dp_status_t                status,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,
    output logic                      m_tuser
);

    localparam int IDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int CMP_W = (RPM_BITS + 3 > 21) ? RPM_BITS + 3 : 21;

    // configuration
    logic use_table_reg, wait_mode_reg;

    // tables
    logic [RPM_BITS-1:0] in_mem  [LEVELS];
    logic [RPM_BITS-1:0] out_mem [LEVELS];
    logic [RPM_BITS-1:0] in_rdata_reg, out_rdata_reg;
    logic [LEVELS-1:0]   in_learned_reg, out_learned_reg;

    // captured item
    logic [LVL_W-1:0] in_level_reg, out_level_reg;
    logic [RPM_W-1:0] in_rpm_reg, out_rpm_reg;
    logic [IDX_W-1:0] in_idx_reg, out_idx_reg;
    logic             in_hit_reg, out_hit_reg;
    logic             in_base_reg, out_base_reg;
    logic             skip_reg;

    // result register
    logic m_tvalid_reg, in_ok_reg, out_ok_reg, skipped_reg;

    // port-side decode
    logic [LVL_W-1:0] p_in_level, p_out_level;
    logic [RPM_W-1:0] p_in_rpm, p_out_rpm;
    logic [IDX_W-1:0] p_in_idx, p_out_idx, p_in_base, p_out_base;
    logic             p_skip;

    // evaluation
    logic in_ok, out_ok, in_wb, out_wb;

    function automatic logic [IDX_W-1:0] clamp_level(input logic [LVL_W-1:0] lvl);
        if (int'(lvl) >= LEVELS) begin
            return IDX_W'(LEVELS - 1);
        end
        return IDX_W'(lvl);
    endfunction

    function automatic logic [IDX_W-1:0] base_of(input logic [IDX_W-1:0] idx);
        return IDX_W'(round_down_ten(8'(idx)));
    endfunction

    function automatic logic judge(
        input logic                use_tbl,
        input logic [LVL_W-1:0]    lvl,
        input logic [RPM_W-1:0]    rpm,
        input logic                hit,
        input logic                base_ok,
        input logic [RPM_BITS-1:0] rdata
    );
        logic [12:0]      fixed_lim;
        logic [CMP_W-1:0] lhs, rhs;
        fixed_lim = 13'(lvl) * 13'(FIXED_RPM_PER_LEVEL);
        // rpm >= floor(6t/10)  <=>  10*(rpm+1) > 6t
        lhs = CMP_W'(rpm) * CMP_W'(THRESH_DEN) + CMP_W'(THRESH_DEN);
        rhs = CMP_W'(rdata) * CMP_W'(THRESH_NUM);
        if (!use_tbl) begin
            return 16'(fixed_lim) < rpm;
        end
        if (int'(lvl) < LOW_LEVEL_LIMIT) begin
            return rpm > RPM_W'(LOW_LEVEL_MIN_RPM);
        end
        if (!hit && !base_ok) begin
            return 1'b1;  // unlearned fallback: zero threshold
        end
        return lhs > rhs;
    endfunction

    assign p_in_level  = s_tdata[IN_LEVEL_LSB +: LVL_W];
    assign p_in_rpm    = s_tdata[IN_RPM_LSB +: RPM_W];
    assign p_out_level = s_tdata[OUT_LEVEL_LSB +: LVL_W];
    assign p_out_rpm   = s_tdata[OUT_RPM_LSB +: RPM_W];
    assign p_in_idx    = clamp_level(p_in_level);
    assign p_out_idx   = clamp_level(p_out_level);
    assign p_in_base   = base_of(p_in_idx);
    assign p_out_base  = base_of(p_out_idx);
    assign p_skip      = !wait_mode_reg
                         && !(s_tdata[IN_STABLE_BIT] && s_tdata[OUT_STABLE_BIT]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_table_reg <= 1'b0;
            wait_mode_reg <= 1'b1;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_USE_TABLE: use_table_reg <= cfg_data;
                REG_WAIT_MODE: wait_mode_reg <= cfg_data;
            endcase
        end
    end

    // item capture and table read; learned entry first, else the tens entry
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_level_reg  <= p_in_level;
            out_level_reg <= p_out_level;
            in_rpm_reg    <= p_in_rpm;
            out_rpm_reg   <= p_out_rpm;
            in_idx_reg    <= p_in_idx;
            out_idx_reg   <= p_out_idx;
            in_hit_reg    <= in_learned_reg[p_in_idx];
            out_hit_reg   <= out_learned_reg[p_out_idx];
            in_base_reg   <= in_learned_reg[p_in_base];
            out_base_reg  <= out_learned_reg[p_out_base];
            skip_reg      <= p_skip;
            in_rdata_reg  <= in_mem[in_learned_reg[p_in_idx] ? p_in_idx : p_in_base];
            out_rdata_reg <= out_mem[out_learned_reg[p_out_idx] ? p_out_idx : p_out_base];
        end
    end

    assign in_ok  = judge(use_table_reg, in_level_reg, in_rpm_reg,
                          in_hit_reg, in_base_reg, in_rdata_reg);
    assign out_ok = judge(use_table_reg, out_level_reg, out_rpm_reg,
                          out_hit_reg, out_base_reg, out_rdata_reg);
    assign in_wb  = cmd.finish && !skip_reg && use_table_reg && !in_hit_reg
                    && int'(in_level_reg) >= LOW_LEVEL_LIMIT;
    assign out_wb = cmd.finish && !skip_reg && use_table_reg && !out_hit_reg
                    && int'(out_level_reg) >= LOW_LEVEL_LIMIT;

    // one write port per table: study writes at accept, write-back at finish
    always_ff @(posedge aclk) begin
        if (cmd.study) begin
            in_mem[p_in_idx]   <= RPM_BITS'(p_in_rpm);
            out_mem[p_out_idx] <= RPM_BITS'(p_out_rpm);
        end else begin
            if (in_wb) begin
                in_mem[in_idx_reg] <= RPM_BITS'(in_rpm_reg);
            end
            if (out_wb) begin
                out_mem[out_idx_reg] <= RPM_BITS'(out_rpm_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_learned_reg  <= '0;
            out_learned_reg <= '0;
        end else if (cmd.study) begin
            in_learned_reg[p_in_idx]   <= 1'b1;
            out_learned_reg[p_out_idx] <= 1'b1;
        end else begin
            if (in_wb) begin
                in_learned_reg[in_idx_reg] <= 1'b1;
            end
            if (out_wb) begin
                out_learned_reg[out_idx_reg] <= 1'b1;
            end
        end
    end

    assign status.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            in_ok_reg   <= skip_reg || in_ok;
            out_ok_reg  <= skip_reg || out_ok;
            skipped_reg <= skip_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - 2){1'b0}}, out_ok_reg, in_ok_reg};
    assign m_tuser  = skipped_reg;

endmodule
`default_nettype wire

FILE: hw/rtl/fan_health_checker_core.sv
// Fan health checker top level: sequencer plus datapath.
//
// Input stream s_*: one word per reading pair. s_tuser is the kind (0 check,
// 1 study sample); s_tdata carries both fans' level/rpm and stable flags.
// Result stream m_*: one word per check, none per study sample.
// m_tdata[0] intake ok, m_tdata[1] exhaust ok; m_tuser is the skipped flag.
// Config channel cfg_*: index 0 use_table, index 1 wait_mode; always ready.
// It is to be written only while the block is quiet; nothing enforces this.
//
// A study sample is written in its accept cycle. For a check, the accept cycle
// reads both rpm tables (one registered read port each); the evaluation state
// then judges, writes back unlearned entries through each table's single write
// port and loads the result word. No new word is accepted during evaluation.
// The result sits in an output register, so the next word is accepted while
// it waits; a check whose result cannot be loaded holds in evaluation until
// m_tready frees the register, with s_tready low.
// Reset clears the learned bits of both tables (all levels unlearned),
// sets use_table to 0 and wait_mode to 1 and empties the output register.
`default_nettype none
module fan_health_checker_core
    import fhc_pkg::*;
#(
    parameter int LEVELS   = 101,
    parameter int RPM_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // in_level, in_rpm, out_level, out_rpm, in_stable, out_stable
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // in_ok, out_ok, zero fill
    output logic [M_TDATA_W-1:0]      m_tdata,
    // skipped
    output logic                      m_tuser,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic                 cfg_data
);

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    fhc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .status   (status)
    );

    fhc_datapath #(
        .LEVELS   (LEVELS),
        .RPM_BITS (RPM_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
`default_nettype wire

FILE: test/fan_verdict_checker.sv
// Fan health checker: watches all channels, predicts each verdict word and compares.
`timescale 1ns / 1ps
module fan_verdict_checker
    import fhc_pkg::*;
#(
    parameter int LEVELS   = 101,
    parameter int RPM_BITS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    input  wire logic                 s_tready,
    // in_level, in_rpm, out_level, out_rpm, in_stable, out_stable
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    // kind
    input  wire logic                 s_tuser,
    input  wire logic                 m_tvalid,
    input  wire logic                 m_tready,
    // in_ok, out_ok, zero fill
    input  wire logic [M_TDATA_W-1:0] m_tdata,
    // skipped
    input  wire logic                 m_tuser,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic                 cfg_index,
    input  wire logic                 cfg_data,
    output int                        mismatches,
    output int                        outstanding
);

    localparam logic KIND_STUDY = 1'b1;
    localparam int   INTAKE     = 0;
    localparam int   EXHAUST    = 1;
    localparam int   LEVEL_STEP = 10;

    typedef struct packed {
        logic in_ok;
        logic out_ok;
        logic skipped;
    } verdict_t;

    logic [RPM_BITS-1:0] learned_rpm [2][LEVELS];
    bit                  learned     [2][LEVELS];
    bit                  table_rule;
    bit                  trust_readings;
    verdict_t            verdicts_due [$];

    function automatic int table_slot(input int level);
        return (level >= LEVELS) ? LEVELS - 1 : level;
    endfunction

    function automatic void store_rpm(input int fan, input int level, input int rpm);
        int slot;
        slot = table_slot(level);
        learned_rpm[fan][slot] = RPM_BITS'(rpm);
        learned[fan][slot]     = 1'b1;
    endfunction

    function automatic logic judge_fan(input int fan, input int level, input int rpm);
        int     slot;
        int     base;
        longint floor_rpm;
        if (!table_rule)
            return rpm > level * FIXED_RPM_PER_LEVEL;
        if (level < LOW_LEVEL_LIMIT)
            return rpm > LOW_LEVEL_MIN_RPM;
        slot = table_slot(level);
        if (learned[fan][slot])
            return rpm >= longint'(learned_rpm[fan][slot]) * THRESH_NUM / THRESH_DEN;
        // unlearned level: fall back to the entry at the level rounded down, then learn it
        base      = slot / LEVEL_STEP * LEVEL_STEP;
        floor_rpm = learned[fan][base]
                  ? longint'(learned_rpm[fan][base]) * THRESH_NUM / THRESH_DEN : 0;
        store_rpm(fan, slot, rpm);
        return rpm >= floor_rpm;
    endfunction

    always @(posedge aclk) begin
        int       in_lvl;
        int       in_rpm;
        int       ex_lvl;
        int       ex_rpm;
        verdict_t due;
        if (!aresetn) begin
            for (int f = 0; f < 2; f++)
                for (int l = 0; l < LEVELS; l++)
                    learned[f][l] = 1'b0;
            table_rule     = 1'b0;
            trust_readings = 1'b1;
            verdicts_due.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_USE_TABLE: table_rule = cfg_data;
                    REG_WAIT_MODE: trust_readings = cfg_data;
                    default: ;
                endcase
            end

            // a word leaving this edge belongs to an item accepted earlier
            if (m_tvalid && m_tready) begin
                if (verdicts_due.size() == 0) begin
                    mismatches++;
                    $display({"%0t: unexpected result word: expected none, ",
                              "got in_ok %b out_ok %b skipped %b"},
                             $time, m_tdata[0], m_tdata[1], m_tuser);
                end else begin
                    due = verdicts_due.pop_front();
                    if (m_tdata[0] !== due.in_ok || m_tdata[1] !== due.out_ok ||
                        m_tuser !== due.skipped || m_tdata[M_TDATA_W-1:2] !== '0) begin
                        mismatches++;
                        $display({"%0t: verdict mismatch: expected in_ok %b out_ok %b ",
                                  "skipped %b fill 0, got in_ok %b out_ok %b skipped %b ",
                                  "fill %h"},
                                 $time, due.in_ok, due.out_ok, due.skipped,
                                 m_tdata[0], m_tdata[1], m_tuser,
                                 m_tdata[M_TDATA_W-1:2]);
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                in_lvl = int'(s_tdata[IN_LEVEL_LSB +: LVL_W]);
                in_rpm = int'(s_tdata[IN_RPM_LSB +: RPM_W]);
                ex_lvl = int'(s_tdata[OUT_LEVEL_LSB +: LVL_W]);
                ex_rpm = int'(s_tdata[OUT_RPM_LSB +: RPM_W]);
                if (s_tuser == KIND_STUDY) begin
                    store_rpm(INTAKE, in_lvl, in_rpm);
                    store_rpm(EXHAUST, ex_lvl, ex_rpm);
                end else if (!trust_readings &&
                             !(s_tdata[IN_STABLE_BIT] && s_tdata[OUT_STABLE_BIT])) begin
                    // still settling: reported as skipped, tables untouched
                    due.in_ok   = 1'b1;
                    due.out_ok  = 1'b1;
                    due.skipped = 1'b1;
                    verdicts_due.push_back(due);
                end else begin
                    due.in_ok   = judge_fan(INTAKE, in_lvl, in_rpm);
                    due.out_ok  = judge_fan(EXHAUST, ex_lvl, ex_rpm);
                    due.skipped = 1'b0;
                    verdicts_due.push_back(due);
                end
            end
        end
        outstanding = verdicts_due.size();
    end

endmodule

FILE: test/tb_fan_health_checker_core.sv
// Testbench top for the fan health checker: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_fan_health_checker_core;
    import fhc_pkg::*;

    localparam int PHASE_ITEMS  = 115;
    localparam int QUIET_CYCLES = 12;
    localparam int RUN_LIMIT    = 200000;
    localparam int RPM_MAX      = (1 << RPM_W) - 1;

    typedef struct {
        bit             study;
        bit [LVL_W-1:0] in_level;
        bit [RPM_W-1:0] in_rpm;
        bit [LVL_W-1:0] ex_level;
        bit [RPM_W-1:0] ex_rpm;
        bit             in_stable;
        bit             ex_stable;
    } fan_pair_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic                 cfg_index = REG_USE_TABLE;
    logic                 cfg_data  = 1'b0;

    int mismatches;
    int outstanding;
    int cycle_count = 0;
    int stall_left  = 0;
    bit calm        = 1'b0;
    int rpm_hint [0:(1 << LVL_W) - 1];

    always #5 aclk = ~aclk;

    fan_health_checker_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    fan_verdict_checker verdict_chk (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("fan_health_checker_core verification failed");
            $finish;
        end
    end

    // result side back-pressure: random stall bursts, none started once calm is set
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!calm && $urandom_range(0, 99) < 20) begin
            stall_left <= $urandom_range(0, 6);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic fan_pair_t make_pair(input bit study, input int il, input int ir,
                                            input int xl, input int xr,
                                            input bit ist, input bit xst);
        fan_pair_t p;
        p.study     = study;
        p.in_level  = LVL_W'(il);
        p.in_rpm    = RPM_W'(ir);
        p.ex_level  = LVL_W'(xl);
        p.ex_rpm    = RPM_W'(xr);
        p.in_stable = ist;
        p.ex_stable = xst;
        return p;
    endfunction

    // mostly table levels, some below the low-level limit, some past the table end
    function automatic int pick_level();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(30, 100);
        if (pick < 85)
            return $urandom_range(0, LOW_LEVEL_LIMIT - 1);
        return $urandom_range(101, (1 << LVL_W) - 1);
    endfunction

    // rpm aimed at the fixed-rule edge or the learned threshold, else wide or tiny
    function automatic int rpm_for(input int level);
        int pick;
        int r;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            r = $urandom_range(0, RPM_MAX);
        else if (pick < 5)
            r = level * FIXED_RPM_PER_LEVEL + int'($urandom_range(0, 4)) - 2;
        else if (pick < 6)
            r = $urandom_range(0, 2 * LOW_LEVEL_MIN_RPM);
        else
            r = rpm_hint[level] * THRESH_NUM / THRESH_DEN + int'($urandom_range(0, 4)) - 2;
        return (r < 0) ? 0 : ((r > RPM_MAX) ? RPM_MAX : r);
    endfunction

    task automatic send_pair(input fan_pair_t p);
        int                   gap;
        logic [S_TDATA_W-1:0] word;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < 25)
            gap = $urandom_range(1, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        word[IN_LEVEL_LSB +: LVL_W]  = p.in_level;
        word[IN_RPM_LSB +: RPM_W]    = p.in_rpm;
        word[OUT_LEVEL_LSB +: LVL_W] = p.ex_level;
        word[OUT_RPM_LSB +: RPM_W]   = p.ex_rpm;
        word[IN_STABLE_BIT]          = p.in_stable;
        word[OUT_STABLE_BIT]         = p.ex_stable;
        // rough guess of table contents, only used to aim later rpm values
        if (p.study || rpm_hint[p.in_level] == 0)
            rpm_hint[p.in_level] = int'(p.in_rpm);
        if (p.study || rpm_hint[p.ex_level] == 0)
            rpm_hint[p.ex_level] = int'(p.ex_rpm);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= p.study;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic apply_config(input logic table_on, input logic trust);
        cfg_valid <= 1'b1;
        cfg_index <= REG_USE_TABLE;
        cfg_data  <= table_on;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_WAIT_MODE;
        cfg_data  <= trust;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // wait for every verdict, then let a study word still in flight finish
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int il;
        int xl;
        for (int l = 0; l < (1 << LVL_W); l++)
            rpm_hint[l] = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // fixed rpm-per-level rule, edges of level and rpm
        apply_config(1'b0, 1'b1);
        send_pair(make_pair(1'b0, 0, 0, 0, 1, 1'b1, 1'b1));
        send_pair(make_pair(1'b0, 100, 3800, 100, 3801, 1'b1, 1'b1));
        send_pair(make_pair(1'b0, 127, 65535, 127, 4826, 1'b0, 1'b0));
        send_pair(make_pair(1'b1, 5, 123, 127, 65535, 1'b1, 1'b1));
        settle();

        // learned table rule
        apply_config(1'b1, 1'b1);
        send_pair(make_pair(1'b0, 29, 10, 29, 11, 1'b1, 1'b1));
        send_pair(make_pair(1'b0, 30, 0, 30, 0, 1'b1, 1'b1));
        send_pair(make_pair(1'b1, 50, 1000, 50, 2000, 1'b1, 1'b1));
        send_pair(make_pair(1'b0, 50, 599, 50, 1200, 1'b1, 1'b1));
        // unlearned levels falling back to level 50, then learned themselves
        send_pair(make_pair(1'b0, 57, 599, 59, 1199, 1'b1, 1'b1));
        send_pair(make_pair(1'b0, 57, 359, 59, 719, 1'b1, 1'b1));
        // levels past the table clamp onto the last entry
        send_pair(make_pair(1'b0, 120, 65535, 101, 0, 1'b1, 1'b1));
        send_pair(make_pair(1'b0, 100, 39320, 100, 39321, 1'b1, 1'b1));
        send_pair(make_pair(1'b0, 83, 0, 40, 0, 1'b1, 1'b1));
        settle();

        // stable flags honored
        apply_config(1'b1, 1'b0);
        send_pair(make_pair(1'b0, 50, 0, 50, 0, 1'b0, 1'b1));
        send_pair(make_pair(1'b0, 50, 0, 50, 0, 1'b1, 1'b0));
        send_pair(make_pair(1'b0, 66, 0, 66, 0, 1'b0, 1'b0));
        send_pair(make_pair(1'b1, 66, 500, 66, 700, 1'b0, 1'b0));
        send_pair(make_pair(1'b0, 66, 300, 66, 419, 1'b1, 1'b1));
        send_pair(make_pair(1'b0, 5, 11, 0, 65535, 1'b1, 1'b1));
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: apply_config(1'b1, 1'b1);
                1: apply_config(1'b0, 1'b0);
                2: apply_config(1'b1, 1'b0);
                3: apply_config(1'b0, 1'b1);
                4: apply_config(1'b1, 1'b1);
                default: apply_config(1'b1, 1'b0);
            endcase
            if (ph == 5)
                calm <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                il = pick_level();
                xl = pick_level();
                send_pair(make_pair($urandom_range(0, 4) == 0, il, rpm_for(il),
                                    xl, rpm_for(xl),
                                    $urandom_range(0, 6) != 0, $urandom_range(0, 6) != 0));
            end
            settle();
        end

        @(negedge aclk);
        if (mismatches == 0 && outstanding == 0)
            $display("fan_health_checker_core verification clean");
        else
            $display("fan_health_checker_core verification failed");
        $finish;
    end

endmodule
